FILE: rtl/core/dcg_pkg.sv
// Shared constants, types and a lookup function for the disk CHS geometry pipeline.
`timescale 1ns / 1ps

package dcg_pkg;

  localparam int BYTES_W       = 64;
  localparam int SECTOR_SHIFT  = 9;
  localparam int TOTAL_W       = 29;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 17;
  localparam int CYL_W         = 16;
  localparam int HEADS_W       = 8;
  localparam int SPT_W         = 8;
  localparam int RECIP_W       = 30;
  localparam int PROD_W        = TOTAL_W + RECIP_W;
  localparam int Q17_SH        = 34;
  localparam int Q31_SH        = 34;
  localparam int Q63_SH        = 35;
  localparam int Q255_SH       = 37;
  localparam int Q17_W         = PROD_W - Q17_SH;
  localparam int Q31_W         = PROD_W - Q31_SH;
  localparam int Q63_W         = PROD_W - Q63_SH;
  localparam int Q255_W        = PROD_W - Q255_SH;
  localparam int CTH_W         = 22;
  localparam int HSEL_W        = 5;
  localparam int CYL_LIMIT_SH  = 10;
  localparam int HRAW_W        = Q17_W + 1 - CYL_LIMIT_SH;
  localparam int BIG_CTH       = 16384;
  localparam int HEAD16_SH     = 4;
  localparam int SMALL_N_W     = 14;
  localparam int SMALL_RECIP_W = 17;
  localparam int SMALL_PROD_W  = SMALL_N_W + SMALL_RECIP_W;
  localparam int SMALL_SH      = 18;
  localparam int SMALL_Q_W     = SMALL_PROD_W - SMALL_SH;

  localparam logic [CFG_IDX_W-1:0] REG_OVR_HEADS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVR_SECTORS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVR_CYLINDERS = 2'd2;

  localparam logic [TOTAL_W-1:0] MAX_TOTAL   = 29'd267382800;
  localparam logic [TOTAL_W-1:0] LARGE_TOTAL = 29'd66059280;

  localparam logic [RECIP_W-1:0] RECIP17  =
    RECIP_W'(((64'd1 << Q17_SH) + 64'd16) / 64'd17);
  localparam logic [RECIP_W-1:0] RECIP31  =
    RECIP_W'(((64'd1 << Q31_SH) + 64'd30) / 64'd31);
  localparam logic [RECIP_W-1:0] RECIP63  =
    RECIP_W'(((64'd1 << Q63_SH) + 64'd62) / 64'd63);
  localparam logic [RECIP_W-1:0] RECIP255 =
    RECIP_W'(((64'd1 << Q255_SH) + 64'd254) / 64'd255);

  localparam logic [9:0]        CYL_ROUND = 10'd1023;
  localparam logic [HSEL_W-1:0] HEADS_MIN = 5'd4;
  localparam logic [HSEL_W-1:0] HEADS_MAX = 5'd16;
  localparam logic [SPT_W-1:0]  SPT_17    = 8'd17;
  localparam logic [SPT_W-1:0]  SPT_31    = 8'd31;
  localparam logic [SPT_W-1:0]  SPT_63    = 8'd63;
  localparam logic [SPT_W-1:0]  SPT_255   = 8'd255;

  typedef struct packed {
    logic              use_ovr;
    logic [CYL_W-1:0]   cylinders;
    logic [HEADS_W-1:0] heads;
    logic [SPT_W-1:0]   sectors;
  } ovr_t;

  typedef struct packed {
    logic              big_disk;
    logic [Q17_W-1:0]  q17;
    logic [Q31_W-1:0]  q31;
    logic [Q63_W-1:0]  q63;
    logic [Q255_W-1:0] q255;
  } quot_t;

  typedef struct packed {
    logic [CTH_W-1:0]  cth;
    logic [HSEL_W-1:0] heads;
    logic [SPT_W-1:0]  spt;
  } geom_t;

  // Rounded-up reciprocals of 2^18 for head counts 4 to 15; exact for 14-bit dividends.
  function automatic logic [SMALL_RECIP_W-1:0] small_recip(input logic [HSEL_W-1:0] h);
    logic [SMALL_RECIP_W-1:0] m;
    case (h)
      5'd4:    m = 17'd65536;
      5'd5:    m = 17'd52429;
      5'd6:    m = 17'd43691;
      5'd7:    m = 17'd37450;
      5'd8:    m = 17'd32768;
      5'd9:    m = 17'd29128;
      5'd10:   m = 17'd26215;
      5'd11:   m = 17'd23832;
      5'd12:   m = 17'd21846;
      5'd13:   m = 17'd20165;
      5'd14:   m = 17'd18725;
      5'd15:   m = 17'd17477;
      default: m = 17'd0;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/core/dcg_cfg.sv
// Override geometry registers and the check that decides whether they apply.
`timescale 1ns / 1ps

module dcg_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [dcg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dcg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output dcg_pkg::ovr_t                   ovr
);
  import dcg_pkg::*;

  logic [HEADS_W-1:0]    heads_r;
  logic [SPT_W-1:0]      sectors_r;
  logic [CFG_DATA_W-1:0] cyl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heads_r   <= '0;
      sectors_r <= '0;
      cyl_r     <= CFG_DATA_W'(65536);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_OVR_HEADS:     heads_r   <= cfg_wdata[HEADS_W-1:0];
        REG_OVR_SECTORS:   sectors_r <= cfg_wdata[SPT_W-1:0];
        REG_OVR_CYLINDERS: cyl_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    ovr.use_ovr   = (heads_r >= HEADS_W'(2)) && (sectors_r >= SPT_W'(2)) &&
                    !cyl_r[CFG_DATA_W-1];
    ovr.cylinders = cyl_r[CYL_W-1:0];
    ovr.heads     = heads_r;
    ovr.sectors   = sectors_r;
  end

endmodule

FILE: rtl/core/dcg_front.sv
// Front stages: sector count with clamp, then all candidate quotients by reciprocal multiply.
`timescale 1ns / 1ps

module dcg_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [dcg_pkg::BYTES_W-1:0]   in_image_bytes,
  output logic                          quot_valid,
  output dcg_pkg::quot_t                quot
);
  import dcg_pkg::*;

  logic               s1_valid_r;
  logic [TOTAL_W-1:0] total_r;
  logic [TOTAL_W-1:0] total_nxt;
  logic               s2_valid_r;
  quot_t              quot_r;
  quot_t              quot_nxt;
  logic [PROD_W-1:0]  prod17;
  logic [PROD_W-1:0]  prod31;
  logic [PROD_W-1:0]  prod63;
  logic [PROD_W-1:0]  prod255;

  always_comb begin
    if ((|in_image_bytes[BYTES_W-1:SECTOR_SHIFT+TOTAL_W]) ||
        (in_image_bytes[SECTOR_SHIFT+TOTAL_W-1:SECTOR_SHIFT] > MAX_TOTAL)) begin
      total_nxt = MAX_TOTAL;
    end else begin
      total_nxt = in_image_bytes[SECTOR_SHIFT+TOTAL_W-1:SECTOR_SHIFT];
    end
  end

  always_comb begin
    prod17            = PROD_W'(total_r) * PROD_W'(RECIP17);
    prod31            = PROD_W'(total_r) * PROD_W'(RECIP31);
    prod63            = PROD_W'(total_r) * PROD_W'(RECIP63);
    prod255           = PROD_W'(total_r) * PROD_W'(RECIP255);
    quot_nxt.big_disk = (total_r >= LARGE_TOTAL);
    quot_nxt.q17      = prod17[PROD_W-1:Q17_SH];
    quot_nxt.q31      = prod31[PROD_W-1:Q31_SH];
    quot_nxt.q63      = prod63[PROD_W-1:Q63_SH];
    quot_nxt.q255     = prod255[PROD_W-1:Q255_SH];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      total_r <= total_nxt;
      quot_r  <= quot_nxt;
    end
  end

  assign quot_valid = s2_valid_r;
  assign quot       = quot_r;

endmodule

FILE: rtl/core/dcg_select.sv
// Selection stage: picks heads, sectors per track and the cylinder-times-heads count.
`timescale 1ns / 1ps

module dcg_select (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            quot_valid,
  input  dcg_pkg::quot_t  quot,
  output logic            geom_valid,
  output dcg_pkg::geom_t  geom
);
  import dcg_pkg::*;

  logic               valid_r;
  geom_t              geom_r;
  geom_t              geom_nxt;
  logic [Q17_W:0]     q17_round;
  logic [HRAW_W-1:0]  heads_raw;
  logic [HRAW_W-1:0]  heads17;
  logic [Q17_W:0]     limit17;
  logic               retry;

  always_comb begin
    q17_round = {1'b0, quot.q17} + (Q17_W+1)'(CYL_ROUND);
    heads_raw = q17_round[Q17_W:CYL_LIMIT_SH];
    heads17   = (heads_raw < HRAW_W'(HEADS_MIN)) ? HRAW_W'(HEADS_MIN) : heads_raw;
    limit17   = {heads17, {CYL_LIMIT_SH{1'b0}}};
    retry     = (heads17 > HRAW_W'(HEADS_MAX)) || ({1'b0, quot.q17} >= limit17);

    if (quot.big_disk) begin
      geom_nxt.cth   = CTH_W'(quot.q255);
      geom_nxt.heads = HEADS_MAX;
      geom_nxt.spt   = SPT_255;
    end else if (retry) begin
      geom_nxt.heads = HEADS_MAX;
      if (quot.q31 >= Q31_W'(BIG_CTH)) begin
        geom_nxt.cth = CTH_W'(quot.q63);
        geom_nxt.spt = SPT_63;
      end else begin
        geom_nxt.cth = CTH_W'(quot.q31);
        geom_nxt.spt = SPT_31;
      end
    end else begin
      geom_nxt.cth   = CTH_W'(quot.q17);
      geom_nxt.heads = heads17[HSEL_W-1:0];
      geom_nxt.spt   = SPT_17;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= quot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geom_r <= geom_nxt;
    end
  end

  assign geom_valid = valid_r;
  assign geom       = geom_r;

endmodule

FILE: rtl/core/dcg_cyl.sv
// Final stage: divides by the head count, applies the override and holds the result beat.
`timescale 1ns / 1ps

module dcg_cyl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          geom_valid,
  input  dcg_pkg::geom_t                geom,
  input  dcg_pkg::ovr_t                 ovr,
  output logic                          out_valid,
  output logic [dcg_pkg::CYL_W-1:0]     out_cylinders,
  output logic [dcg_pkg::HEADS_W-1:0]   out_heads,
  output logic [dcg_pkg::SPT_W-1:0]     out_sectors_per_track,
  output logic                          out_from_override
);
  import dcg_pkg::*;

  logic                     valid_r;
  logic [CYL_W-1:0]         cyl_r;
  logic [CYL_W-1:0]         cyl_nxt;
  logic [HEADS_W-1:0]       heads_r;
  logic [HEADS_W-1:0]       heads_nxt;
  logic [SPT_W-1:0]         spt_r;
  logic [SPT_W-1:0]         spt_nxt;
  logic                     ovr_r;
  logic [SMALL_PROD_W-1:0]  small_prod;

  always_comb begin
    small_prod = SMALL_PROD_W'(geom.cth[SMALL_N_W-1:0]) *
                 SMALL_PROD_W'(small_recip(geom.heads));
    if (ovr.use_ovr) begin
      cyl_nxt   = ovr.cylinders;
      heads_nxt = ovr.heads;
      spt_nxt   = ovr.sectors;
    end else begin
      if (geom.heads == HEADS_MAX) begin
        cyl_nxt = geom.cth[HEAD16_SH+CYL_W-1:HEAD16_SH];
      end else begin
        cyl_nxt = CYL_W'(small_prod[SMALL_PROD_W-1:SMALL_SH]);
      end
      heads_nxt = HEADS_W'(geom.heads);
      spt_nxt   = geom.spt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= geom_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cyl_r   <= cyl_nxt;
      heads_r <= heads_nxt;
      spt_r   <= spt_nxt;
      ovr_r   <= ovr.use_ovr;
    end
  end

  assign out_valid             = valid_r;
  assign out_cylinders         = cyl_r;
  assign out_heads             = heads_r;
  assign out_sectors_per_track = spt_r;
  assign out_from_override     = ovr_r;

endmodule

FILE: rtl/core/disk_chs_geometry_unit.sv
// Top level of the disk CHS geometry unit: image size in, cylinder/head/sector geometry out.
// The input channel takes one image size in bytes per beat (in_valid, in_stall,
// in_image_bytes). Each input beat yields exactly one result beat on the output
// channel (out_valid, out_stall and the four geometry fields), in order.
// The configuration port writes the override heads, sectors and cylinders
// registers on any cycle with cfg_wr_en high; write them only while no item is
// in flight. A usable override is returned unchanged with out_from_override set.
// The datapath is a four-stage pipeline: sector clamp, reciprocal multiplies by
// 17, 31, 63 and 255, geometry selection, and the final divide by the head count
// into the output register. One beat is taken every cycle unless in_stall is high,
// so the sustained rate is one item per cycle while the receiver does not stall.
// When the receiver stalls while a result is held, the whole pipeline freezes
// and in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset is synchronous and active low. It empties the pipeline and returns the
// override registers to heads 0, sectors 0, cylinders 65536 (override off).
`timescale 1ns / 1ps

module disk_chs_geometry_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dcg_pkg::BYTES_W-1:0]     in_image_bytes,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dcg_pkg::CYL_W-1:0]       out_cylinders,
  output logic [dcg_pkg::HEADS_W-1:0]     out_heads,
  output logic [dcg_pkg::SPT_W-1:0]       out_sectors_per_track,
  output logic                            out_from_override,
  input  logic                            cfg_wr_en,
  input  logic [dcg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dcg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dcg_pkg::*;

  logic  adv;
  ovr_t  ovr;
  logic  quot_valid;
  quot_t quot;
  logic  geom_valid;
  geom_t geom;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  dcg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ovr       (ovr)
  );

  dcg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_valid       (in_valid),
    .in_image_bytes (in_image_bytes),
    .quot_valid     (quot_valid),
    .quot           (quot)
  );

  dcg_select u_select (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .quot_valid (quot_valid),
    .quot       (quot),
    .geom_valid (geom_valid),
    .geom       (geom)
  );

  dcg_cyl u_cyl (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .adv                   (adv),
    .geom_valid            (geom_valid),
    .geom                  (geom),
    .ovr                   (ovr),
    .out_valid             (out_valid),
    .out_cylinders         (out_cylinders),
    .out_heads             (out_heads),
    .out_sectors_per_track (out_sectors_per_track),
    .out_from_override     (out_from_override)
  );

endmodule

FILE: rtl/core/dcg_checker.sv
// Port-level assertions for the disk CHS geometry unit and their bind.
`timescale 1ns / 1ps

module dcg_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [dcg_pkg::CYL_W-1:0]       out_cylinders,
  input logic [dcg_pkg::HEADS_W-1:0]     out_heads,
  input logic [dcg_pkg::SPT_W-1:0]       out_sectors_per_track,
  input logic                            out_from_override
);
  import dcg_pkg::*;

  // A held result beat keeps its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cylinders) &&
    $stable(out_heads) && $stable(out_sectors_per_track) && $stable(out_from_override))
    else $error("result beat changed while stalled");

  // The input side is held off only while a finished result waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // Computed geometry uses one of the four track sizes and 4 to 16 heads.
  a_calc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_from_override |->
    (out_heads >= HEADS_W'(HEADS_MIN)) && (out_heads <= HEADS_W'(HEADS_MAX)) &&
    ((out_sectors_per_track == SPT_17) || (out_sectors_per_track == SPT_31) ||
     (out_sectors_per_track == SPT_63) || (out_sectors_per_track == SPT_255)))
    else $error("computed geometry out of range");

  // Any track size other than 17 forces 16 heads.
  a_calc_heads: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_from_override && (out_sectors_per_track != SPT_17) |->
    out_heads == HEADS_W'(HEADS_MAX))
    else $error("wide track size without 16 heads");

  // An override is only reported for a usable configured geometry.
  a_ovr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_from_override |->
    (out_heads >= HEADS_W'(2)) && (out_sectors_per_track >= SPT_W'(2)))
    else $error("override reported with unusable geometry");

endmodule

bind disk_chs_geometry_unit dcg_checker u_dcg_checker (.*);

FILE: sim/tb_disk_chs_geometry_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the disk CHS geometry unit with a result scoreboard.

class geometry_scoreboard;
  typedef struct packed {
    logic [15:0] cylinders;
    logic [7:0]  heads;
    logic [7:0]  sectors;
    logic        from_override;
  } chs_t;

  localparam longint unsigned SECTOR_CAP   = 64'd65535 * 64'd16 * 64'd255;
  localparam longint unsigned LARGE_CUTOFF = 64'd65535 * 64'd16 * 64'd63;
  localparam longint unsigned CYL_SPAN     = 64'd1024;

  bit [7:0]  ovr_heads;
  bit [7:0]  ovr_sectors;
  bit [16:0] ovr_cylinders;
  chs_t      pending_geometry[$];
  int        errors;
  int        checked;

  function new();
    ovr_heads     = 8'd0;
    ovr_sectors   = 8'd0;
    ovr_cylinders = 17'd65536;
    errors        = 0;
    checked       = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [16:0] value);
    case (idx)
      dcg_pkg::REG_OVR_HEADS:     ovr_heads = value[7:0];
      dcg_pkg::REG_OVR_SECTORS:   ovr_sectors = value[7:0];
      dcg_pkg::REG_OVR_CYLINDERS: ovr_cylinders = value;
      default: ;
    endcase
  endfunction

  function chs_t expected_geometry(logic [63:0] image_bytes);
    longint unsigned total, cth, heads, spt;
    chs_t g;
    if (ovr_heads >= 8'd2 && ovr_sectors >= 8'd2 && ovr_cylinders < 17'd65536) begin
      g.cylinders     = ovr_cylinders[15:0];
      g.heads         = ovr_heads;
      g.sectors       = ovr_sectors;
      g.from_override = 1'b1;
      return g;
    end
    total = image_bytes >> 9;
    if (total > SECTOR_CAP) total = SECTOR_CAP;
    if (total >= LARGE_CUTOFF) begin
      heads = 16;
      spt   = 255;
      cth   = total / 255;
    end else begin
      spt   = 17;
      cth   = total / 17;
      heads = (cth + CYL_SPAN - 1) / CYL_SPAN;
      if (heads < 4) heads = 4;
      if (cth >= heads * CYL_SPAN || heads > 16) begin
        heads = 16;
        spt   = 31;
        cth   = total / 31;
      end
      if (cth >= heads * CYL_SPAN) begin
        heads = 16;
        spt   = 63;
        cth   = total / 63;
      end
    end
    g.cylinders     = 16'(cth / heads);
    g.heads         = 8'(heads);
    g.sectors       = 8'(spt);
    g.from_override = 1'b0;
    return g;
  endfunction

  function void note_input(logic [63:0] image_bytes);
    pending_geometry.push_back(expected_geometry(image_bytes));
  endfunction

  task report(string what, longint unsigned got, longint unsigned want);
    errors++;
    if (errors <= 40) $display("mismatch on %s: got %0d, expected %0d", what, got, want);
  endtask

  task check_result(logic [15:0] cyl, logic [7:0] hds, logic [7:0] spt, logic ovr);
    chs_t want;
    checked++;
    if (pending_geometry.size() == 0) begin
      report("unexpected beat", 0, 0);
      return;
    end
    want = pending_geometry.pop_front();
    if (cyl !== want.cylinders) report("cylinders", cyl, want.cylinders);
    if (hds !== want.heads) report("heads", hds, want.heads);
    if (spt !== want.sectors) report("sectors_per_track", spt, want.sectors);
    if (ovr !== want.from_override) report("from_override", ovr, want.from_override);
  endtask
endclass

module tb_disk_chs_geometry_unit;
  import dcg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam longint unsigned LARGE_SECTORS = 64'd66059280;
  localparam longint unsigned CAP_SECTORS   = 64'd267382800;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [BYTES_W-1:0]    in_image_bytes;
  logic                  out_valid;
  logic                  out_stall;
  logic [CYL_W-1:0]      out_cylinders;
  logic [HEADS_W-1:0]    out_heads;
  logic [SPT_W-1:0]      out_sectors_per_track;
  logic                  out_from_override;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  geometry_scoreboard sb;

  disk_chs_geometry_unit dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_image_bytes        (in_image_bytes),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_cylinders         (out_cylinders),
    .out_heads             (out_heads),
    .out_sectors_per_track (out_sectors_per_track),
    .out_from_override     (out_from_override),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_disk_chs_geometry_unit: FAIL");
    $finish;
  end

  function automatic logic [63:0] random_image_size();
    logic [63:0] v;
    longint unsigned base;
    int w;
    case ($urandom_range(0, 9))
      0: v = {$urandom, $urandom};
      1, 2, 3, 4: begin
        w = $urandom_range(1, 64);
        v = {$urandom, $urandom};
        v = v >> (64 - w);
      end
      5, 6: begin
        w = $urandom_range(9, 35);
        v = {$urandom, $urandom};
        v = v >> (64 - w);
      end
      7, 8: begin
        case ($urandom_range(0, 5))
          0: base = 64'd17 * 64'd1024 * $urandom_range(1, 18);
          1: base = 64'd17 * 64'd16384;
          2: base = 64'd31 * 64'd16384;
          3: base = LARGE_SECTORS;
          4: base = CAP_SECTORS;
          default: base = 64'd40;
        endcase
        base = base - 64'd40 + $urandom_range(0, 80);
        v = (base << 9) | 64'($urandom_range(0, 511));
      end
      default: begin
        base = LARGE_SECTORS + $urandom_range(0, 32'(CAP_SECTORS - LARGE_SECTORS + 1000));
        v = (base << 9) | 64'($urandom_range(0, 511));
      end
    endcase
    return v;
  endfunction

  task drive_item(logic [63:0] image_bytes);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_image_bytes <= image_bytes;
    do @(posedge clk); while (in_stall);
    sb.note_input(image_bytes);
  endtask

  task idle_input(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task send_items(int count);
    int left, burst, gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && left > 0) begin
        drive_item(random_image_size());
        burst--;
        left--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) idle_input(gap);
    end
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task configure(logic [7:0] hds, logic [7:0] spt, logic [16:0] cyl);
    write_reg(REG_OVR_HEADS, {9'($urandom), hds});
    write_reg(REG_OVR_SECTORS, {9'($urandom), spt});
    write_reg(REG_OVR_CYLINDERS, cyl);
  endtask

  task drain_pipeline();
    idle_input(1);
    while (sb.pending_geometry.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_cylinders, out_heads, out_sectors_per_track, out_from_override);
  end

  initial begin
    int mode, span, hold;
    bit held;
    mode = 0;
    span = 0;
    hold = 0;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 120);
      end
      span--;
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (!held && sb != null && sb.checked >= 200) begin
        held = 1'b1;
        hold = 60;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  initial begin
    logic [63:0] directed[$];
    sb = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_image_bytes = '0;
    cfg_wr_en      = 1'b0;
    cfg_index      = REG_OVR_HEADS;
    cfg_wdata      = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    directed = '{64'd0, 64'd511, 64'd512, 64'd1023, 64'hFFFF_FFFF_FFFF_FFFF,
                 CAP_SECTORS << 9, (CAP_SECTORS << 9) + 64'd511,
                 (CAP_SECTORS << 9) + 64'd512, (LARGE_SECTORS << 9) - 64'd1,
                 LARGE_SECTORS << 9, 64'd17 * 64'd4096 * 64'd512,
                 64'd17 * 64'd4096 * 64'd512 - 64'd1, 64'd17 * 64'd16384 * 64'd512,
                 64'd17 * 64'd16384 * 64'd512 - 64'd512, 64'd31 * 64'd16384 * 64'd512,
                 64'd31 * 64'd16384 * 64'd512 - 64'd512, 64'd17 * 64'd1024 * 64'd512,
                 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555,
                 64'hAAAA_AAAA_AAAA_AAAA, 64'd63 * 64'd16 * 64'd1023 * 64'd512};
    foreach (directed[i]) drive_item(directed[i]);
    send_items(350);
    drain_pipeline();

    configure(8'd255, 8'd255, 17'd65535);
    send_items(100);
    drain_pipeline();

    configure(8'd2, 8'd2, 17'd0);
    write_reg(REG_SPARE, 17'h1FFFF);
    send_items(100);
    drain_pipeline();

    configure(8'd1, 8'd255, 17'd100);
    send_items(250);
    drain_pipeline();

    configure(8'd200, 8'd0, 17'd5000);
    send_items(150);
    drain_pipeline();

    configure(8'd16, 8'd63, 17'd65536);
    send_items(150);
    drain_pipeline();

    configure(8'd100, 8'd50, 17'd131071);
    send_items(150);
    drain_pipeline();

    configure(8'($urandom_range(2, 255)), 8'($urandom_range(2, 255)),
              17'($urandom_range(0, 65535)));
    send_items(100);
    drain_pipeline();

    configure(8'd0, 8'd0, 17'd65536);
    send_items(250);
    drain_pipeline();

    repeat (12) @(posedge clk);
    if (sb.errors == 0 && sb.pending_geometry.size() == 0) begin
      $display("tb_disk_chs_geometry_unit: PASS");
    end else begin
      $display("tb_disk_chs_geometry_unit: FAIL");
    end
    $finish;
  end
endmodule
